// File: sv/estx_rx_pkg.sv
// ----------------------------------------------------------------------------
// estx_rx_pkg
// shared types and constants of the enq/stx/lrc frame receiver
// ----------------------------------------------------------------------------
package estx_rx_pkg;

  localparam int MAX_LEN_DEF = 256;

  // request kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  // control characters
  localparam logic [7:0] CH_ENQ  = 8'h05;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NACK = 8'h15;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_ETX  = 8'h03;

  localparam logic [19:0] MIN_ENQ_WAIT = 20'd1500;
  localparam logic [15:0] REPLY_WAIT_RST = 16'd600;
  localparam logic [15:0] INTERBYTE_WAIT_RST = 16'd33;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_WAIT     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERBYTE_WAIT = 4'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [19:0] first_wait;
    logic [8:0]  buffer_size;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       finished;
    logic       success;
  } out_item_t;

endpackage

// File: sv/enq_stx_lrc_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// enq_stx_lrc_frame_receiver_core
// receiving side of an enq/ack, stx-message-etx-lrc, ack/nack, eot link
//
// Usage:
//   in_*   : one request per accepted item: a received byte, a 1 ms tick,
//            a line error or a start command (with first wait and buffer size)
//   out_*  : at most one result per request: a control byte to transmit,
//            a buffer write, or the finished/success pair
//   cfg_*  : writes of the reply and inter-byte wait registers, always ready;
//            write only while no request is in flight
//   Each request is handled in the cycle it is accepted; its result appears
//   in the output register on the next cycle. While in_ready is high, one
//   request can be accepted every cycle, set by a single state update per request.
//   When the output register holds a result that is not taken, in_ready drops
//   until out_ready takes it; any request waits then, even one with no result.
//   Reset (rst_n low, synchronous) returns to idle with the wait registers at
//   600 and 33 ticks and an empty output register.
// ----------------------------------------------------------------------------
module enq_stx_lrc_frame_receiver_core #(
  parameter int MAX_LEN = estx_rx_pkg::MAX_LEN_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  estx_rx_pkg::in_item_t                  in_item,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output estx_rx_pkg::out_item_t                 out_item,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [estx_rx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                            cfg_wdata
);
  import estx_rx_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ENQ   = 3'd1,
    PH_STX   = 3'd2,
    PH_FRAME = 3'd3,
    PH_LRC   = 3'd4,
    PH_EOT   = 3'd5
  } phase_t;

  localparam int         CapMax   = (MAX_LEN > 511) ? 511 : MAX_LEN;
  localparam logic [8:0] CAP_CLAMP = 9'(CapMax);

  phase_t      phase_r, phase_nxt;
  logic [19:0] wait_cnt_r, wait_cnt_nxt;
  logic [7:0]  lrc_r, lrc_nxt;
  logic [7:0]  wr_pos_r, wr_pos_nxt;
  logic        frame_good_r, frame_good_nxt;
  logic        msg_good_r, msg_good_nxt;
  logic [19:0] enq_limit_r, enq_limit_nxt;
  logic [8:0]  capacity_r, capacity_nxt;
  logic [15:0] reply_wait_r, interbyte_wait_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic        in_fire;
  logic        res_vld;
  out_item_t   res;
  logic [19:0] wait_inc;
  logic [19:0] cur_limit;
  logic        timed_out;
  logic [8:0]  pos_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign wait_inc  = wait_cnt_r + 20'd1;
  assign timed_out = (wait_inc >= cur_limit);
  assign pos_inc   = {1'b0, wr_pos_r} + 9'd1;

  always_comb begin
    unique case (phase_r)
      PH_ENQ:         cur_limit = enq_limit_r;
      PH_STX, PH_EOT: cur_limit = {4'd0, reply_wait_r};
      default:        cur_limit = {4'd0, interbyte_wait_r};
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    wait_cnt_nxt   = wait_cnt_r;
    lrc_nxt        = lrc_r;
    wr_pos_nxt     = wr_pos_r;
    frame_good_nxt = frame_good_r;
    msg_good_nxt   = msg_good_r;
    enq_limit_nxt  = enq_limit_r;
    capacity_nxt   = capacity_r;
    res            = '0;
    res_vld        = 1'b0;

    if (in_fire) begin
      case (in_item.kind)
        KIND_START: begin
          frame_good_nxt = 1'b0;
          msg_good_nxt   = 1'b0;
          lrc_nxt        = '0;
          wr_pos_nxt     = '0;
          wait_cnt_nxt   = '0;
          if (in_item.buffer_size == 9'd0) begin
            phase_nxt    = PH_IDLE;
            res.finished = 1'b1;
            res_vld      = 1'b1;
          end else begin
            enq_limit_nxt = (in_item.first_wait < MIN_ENQ_WAIT) ? MIN_ENQ_WAIT
                                                                : in_item.first_wait;
            capacity_nxt  = (in_item.buffer_size > CAP_CLAMP) ? CAP_CLAMP
                                                              : in_item.buffer_size;
            phase_nxt     = PH_ENQ;
          end
        end

        KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            wait_cnt_nxt = wait_inc;
            if (timed_out) begin
              wait_cnt_nxt = '0;
              unique case (phase_r)
                PH_ENQ: begin
                  phase_nxt    = PH_IDLE;
                  res.finished = 1'b1;
                  res.success  = msg_good_r;
                  res_vld      = 1'b1;
                end
                PH_STX, PH_EOT: phase_nxt = PH_ENQ;
                PH_FRAME, PH_LRC: begin
                  phase_nxt      = PH_STX;
                  res.send_valid = 1'b1;
                  res.send_byte  = CH_NACK;
                  res_vld        = 1'b1;
                end
                default: phase_nxt = phase_r;
              endcase
            end
          end
        end

        KIND_ERROR: begin
          unique case (phase_r)
            PH_IDLE: phase_nxt = phase_r;
            PH_ENQ:  wait_cnt_nxt = '0;
            PH_STX: begin
              frame_good_nxt = 1'b0;
              msg_good_nxt   = 1'b0;
              wr_pos_nxt     = '0;
              lrc_nxt        = '0;
              wait_cnt_nxt   = '0;
              phase_nxt      = PH_FRAME;
            end
            PH_FRAME: begin
              frame_good_nxt = 1'b0;
              wait_cnt_nxt   = '0;
            end
            PH_LRC: begin
              phase_nxt      = PH_STX;
              wait_cnt_nxt   = '0;
              res.send_valid = 1'b1;
              res.send_byte  = CH_NACK;
              res_vld        = 1'b1;
            end
            PH_EOT: begin
              phase_nxt    = PH_ENQ;
              wait_cnt_nxt = '0;
            end
            default: phase_nxt = phase_r;
          endcase
        end

        default: begin
          unique case (phase_r)
            PH_IDLE: phase_nxt = phase_r;
            PH_ENQ: begin
              wait_cnt_nxt = '0;
              if (in_item.rx_byte == CH_ENQ) begin
                phase_nxt      = PH_STX;
                res.send_valid = 1'b1;
                res.send_byte  = CH_ACK;
                res_vld        = 1'b1;
              end
            end
            PH_STX: begin
              wait_cnt_nxt = '0;
              if (in_item.rx_byte == CH_EOT) begin
                phase_nxt = PH_ENQ;
              end else begin
                frame_good_nxt = (in_item.rx_byte == CH_STX);
                msg_good_nxt   = 1'b0;
                wr_pos_nxt     = '0;
                lrc_nxt        = '0;
                phase_nxt      = PH_FRAME;
              end
            end
            PH_FRAME: begin
              wait_cnt_nxt    = '0;
              lrc_nxt         = lrc_r ^ in_item.rx_byte;
              res.store_valid = 1'b1;
              res.store_index = wr_pos_r;
              res_vld         = 1'b1;
              if (in_item.rx_byte == CH_ETX) begin
                phase_nxt = PH_LRC;
              end else begin
                res.store_byte = in_item.rx_byte;
                if (pos_inc < capacity_r) begin
                  wr_pos_nxt = pos_inc[7:0];
                end else begin
                  frame_good_nxt = 1'b0;
                end
              end
            end
            PH_LRC: begin
              wait_cnt_nxt   = '0;
              res.send_valid = 1'b1;
              res_vld        = 1'b1;
              if (!frame_good_r || (in_item.rx_byte != lrc_r)) begin
                phase_nxt     = PH_STX;
                res.send_byte = CH_NACK;
              end else begin
                msg_good_nxt  = 1'b1;
                phase_nxt     = PH_EOT;
                res.send_byte = CH_ACK;
              end
            end
            PH_EOT: begin
              wait_cnt_nxt = '0;
              if (in_item.rx_byte == CH_STX) begin
                msg_good_nxt = 1'b0;
                wr_pos_nxt   = '0;
                lrc_nxt      = '0;
                phase_nxt    = PH_FRAME;
              end else if (in_item.rx_byte == CH_EOT) begin
                phase_nxt    = PH_IDLE;
                res.finished = 1'b1;
                res.success  = 1'b1;
                res_vld      = 1'b1;
              end else begin
                phase_nxt = PH_ENQ;
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
      endcase
    end

    if (res_vld) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_item_nxt  = out_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      wait_cnt_r       <= '0;
      lrc_r            <= '0;
      wr_pos_r         <= '0;
      frame_good_r     <= 1'b0;
      msg_good_r       <= 1'b0;
      enq_limit_r      <= MIN_ENQ_WAIT;
      capacity_r       <= 9'd1;
      reply_wait_r     <= REPLY_WAIT_RST;
      interbyte_wait_r <= INTERBYTE_WAIT_RST;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      lrc_r        <= lrc_nxt;
      wr_pos_r     <= wr_pos_nxt;
      frame_good_r <= frame_good_nxt;
      msg_good_r   <= msg_good_nxt;
      enq_limit_r  <= enq_limit_nxt;
      capacity_r   <= capacity_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_REPLY_WAIT:     reply_wait_r     <= cfg_wdata;
          REG_INTERBYTE_WAIT: interbyte_wait_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // exactly one kind of result per item
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_item_r.send_valid, out_item_r.store_valid,
                             out_item_r.finished}))
    else $error("result carries more than one kind");

  // control bytes are only ack or nack
  a_send_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.send_valid) |->
      (out_item_r.send_byte == CH_ACK || out_item_r.send_byte == CH_NACK))
    else $error("bad control byte");

  // a finish result leaves the block idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_vld && res.finished) |=> (phase_r == PH_IDLE))
    else $error("not idle after finish");

  // the write position never leaves the buffer
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wr_pos_r} < capacity_r))
    else $error("write position beyond capacity");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the enq/stx/lrc frame receiver core: directed tests
// walk every protocol path, buffer limit and timeout, then random sessions run
// under several wait settings, most with random request gaps and result stalls;
// every result is compared field by field with an in-bench protocol model
// ----------------------------------------------------------------------------
module tb;
  import estx_rx_pkg::*;

  localparam int RX_MAX_LEN   = MAX_LEN_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ENQ, PH_STX, PH_FRAME, PH_LRC, PH_EOT
  } rx_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  rx_phase_t   m_phase;
  logic [19:0] m_wait_cnt;
  logic [7:0]  m_lrc;
  logic [7:0]  m_wpos;
  logic        m_frame_ok;
  logic        m_msg_ok;
  logic [19:0] m_enq_limit;
  logic [8:0]  m_capacity;
  logic [15:0] m_reply_wait;
  logic [15:0] m_gap_wait;

  out_item_t rx_expected[$];
  int        errors;
  int        cycle_count = 0;
  int        n_sent;
  int        ready_hold;
  bit        calm;
  bit        noisy;

  enq_stx_lrc_frame_receiver_core #(
    .MAX_LEN(RX_MAX_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void m_enter(rx_phase_t p);
    m_phase = p;
    m_wait_cnt = '0;
  endfunction

  function automatic void m_begin_frame();
    m_msg_ok = 1'b0;
    m_wpos = '0;
    m_lrc = '0;
    m_enter(PH_FRAME);
  endfunction

  function automatic out_item_t m_finish(logic ok);
    out_item_t res;
    res = '0;
    res.finished = 1'b1;
    res.success = ok;
    m_enter(PH_IDLE);
    return res;
  endfunction

  function automatic out_item_t m_control(logic [7:0] c);
    out_item_t res;
    res = '0;
    res.send_valid = 1'b1;
    res.send_byte = c;
    return res;
  endfunction

  function automatic bit rx_protocol_step(input in_item_t rq, output out_item_t res);
    logic [19:0] limit;
    logic [7:0]  b;
    b = rq.rx_byte;
    res = '0;
    if (rq.kind == KIND_START) begin
      m_frame_ok = 1'b0;
      m_msg_ok = 1'b0;
      m_lrc = '0;
      m_wpos = '0;
      if (rq.buffer_size == '0) begin
        res = m_finish(1'b0);
        return 1'b1;
      end
      m_enq_limit = (rq.first_wait < MIN_ENQ_WAIT) ? MIN_ENQ_WAIT : rq.first_wait;
      m_capacity = (rq.buffer_size > RX_MAX_LEN) ? 9'(RX_MAX_LEN) : rq.buffer_size;
      m_enter(PH_ENQ);
      return 1'b0;
    end
    if (m_phase == PH_IDLE) return 1'b0;
    case (rq.kind)
      KIND_TICK: begin
        case (m_phase)
          PH_ENQ:         limit = m_enq_limit;
          PH_STX, PH_EOT: limit = {4'd0, m_reply_wait};
          default:        limit = {4'd0, m_gap_wait};
        endcase
        m_wait_cnt = m_wait_cnt + 20'd1;
        if (m_wait_cnt < limit) return 1'b0;
        case (m_phase)
          PH_ENQ: begin
            res = m_finish(m_msg_ok);
            return 1'b1;
          end
          PH_STX, PH_EOT: begin
            m_enter(PH_ENQ);
            return 1'b0;
          end
          default: begin
            m_enter(PH_STX);
            res = m_control(CH_NACK);
            return 1'b1;
          end
        endcase
      end
      KIND_ERROR: begin
        case (m_phase)
          PH_ENQ: m_wait_cnt = '0;
          PH_STX: begin
            m_frame_ok = 1'b0;
            m_begin_frame();
          end
          PH_FRAME: begin
            m_frame_ok = 1'b0;
            m_wait_cnt = '0;
          end
          PH_LRC: begin
            m_enter(PH_STX);
            res = m_control(CH_NACK);
            return 1'b1;
          end
          default: m_enter(PH_ENQ);
        endcase
        return 1'b0;
      end
      default: begin
        case (m_phase)
          PH_ENQ: begin
            m_wait_cnt = '0;
            if (b != CH_ENQ) return 1'b0;
            m_enter(PH_STX);
            res = m_control(CH_ACK);
            return 1'b1;
          end
          PH_STX: begin
            if (b == CH_EOT) begin
              m_enter(PH_ENQ);
            end else begin
              m_frame_ok = (b == CH_STX);
              m_begin_frame();
            end
            return 1'b0;
          end
          PH_FRAME: begin
            m_wait_cnt = '0;
            m_lrc = m_lrc ^ b;
            res.store_valid = 1'b1;
            res.store_index = m_wpos;
            if (b == CH_ETX) begin
              m_enter(PH_LRC);
            end else begin
              res.store_byte = b;
              if (int'(m_wpos) + 1 < int'(m_capacity)) m_wpos = m_wpos + 8'd1;
              else m_frame_ok = 1'b0;
            end
            return 1'b1;
          end
          PH_LRC: begin
            if (!m_frame_ok || b != m_lrc) begin
              m_enter(PH_STX);
              res = m_control(CH_NACK);
            end else begin
              m_msg_ok = 1'b1;
              m_enter(PH_EOT);
              res = m_control(CH_ACK);
            end
            return 1'b1;
          end
          default: begin
            if (b == CH_STX) begin
              m_begin_frame();
            end else if (b == CH_EOT) begin
              res = m_finish(1'b1);
              return 1'b1;
            end else begin
              m_enter(PH_ENQ);
            end
            return 1'b0;
          end
        endcase
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 200) $display("%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic send_request(in_item_t rq);
    out_item_t res;
    int        gap;
    int        r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= rq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (rx_protocol_step(rq, res)) rx_expected.push_back(res);
  endtask

  task automatic put(logic [1:0] kind, logic [7:0] b);
    in_item_t rq;
    rq.kind = kind;
    rq.rx_byte = b;
    rq.first_wait = 20'($urandom);
    rq.buffer_size = 9'($urandom);
    send_request(rq);
  endtask

  task automatic start_rx(logic [19:0] fw, logic [8:0] bs);
    in_item_t rq;
    rq.kind = KIND_START;
    rq.rx_byte = 8'($urandom);
    rq.first_wait = fw;
    rq.buffer_size = bs;
    send_request(rq);
  endtask

  task automatic line_noise();
    int r;
    if (!noisy || $urandom_range(0, 99) >= 12) return;
    r = $urandom_range(0, 99);
    if (r < 60) repeat ($urandom_range(1, 3)) put(KIND_TICK, 8'($urandom));
    else if (r < 80) put(KIND_ERROR, 8'($urandom));
    else if (r < 96) put(KIND_BYTE, 8'($urandom));
    else start_rx(20'($urandom), 9'($urandom_range(0, 8)));
  endtask

  // body bytes, etx, then the lrc (corrupted when lrc_ok is low)
  task automatic send_frame(int len, bit lrc_ok);
    logic [7:0] lrc_acc;
    logic [7:0] b;
    lrc_acc = '0;
    repeat (len) begin
      b = 8'($urandom);
      if (b == CH_ETX) b = 8'hA5;
      lrc_acc = lrc_acc ^ b;
      put(KIND_BYTE, b);
      line_noise();
    end
    lrc_acc = lrc_acc ^ CH_ETX;
    put(KIND_BYTE, CH_ETX);
    line_noise();
    put(KIND_BYTE, lrc_ok ? lrc_acc : lrc_acc ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rx_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wait_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_REPLY_WAIT) m_reply_wait = val;
    else m_gap_wait = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_waits(logic [15:0] reply, logic [15:0] gap);
    write_wait_reg(REG_REPLY_WAIT, reply);
    write_wait_reg(REG_INTERBYTE_WAIT, gap);
  endtask

  task automatic test_idle_requests();
    put(KIND_BYTE, CH_ENQ);
    put(KIND_TICK, 8'($urandom));
    put(KIND_ERROR, 8'($urandom));
    start_rx(20'd0, 9'd0);
  endtask

  task automatic test_clean_message();
    start_rx(20'hFFFFF, 9'd16);
    put(KIND_ERROR, 8'($urandom));
    put(KIND_BYTE, 8'h41);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(3, 1'b1);
    put(KIND_BYTE, CH_EOT);
  endtask

  task automatic test_rejected_frames();
    start_rx(20'd1499, 9'd8);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(2, 1'b0);
    // junk opener: frame starts already bad
    put(KIND_BYTE, 8'h7E);
    send_frame(1, 1'b1);
    put(KIND_ERROR, 8'($urandom));
    send_frame(1, 1'b1);
    put(KIND_BYTE, CH_STX);
    put(KIND_BYTE, 8'h11);
    put(KIND_ERROR, 8'($urandom));
    send_frame(0, 1'b1);
    put(KIND_BYTE, CH_STX);
    put(KIND_BYTE, 8'h22);
    put(KIND_BYTE, CH_ETX);
    put(KIND_ERROR, 8'($urandom));
    put(KIND_BYTE, CH_EOT);
  endtask

  task automatic test_buffer_limits();
    start_rx(20'd0, 9'd1);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(2, 1'b1);
    start_rx(20'd0, 9'd2);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(4, 1'b1);
    // oversized request clamps to the max length
    start_rx(20'd0, 9'h1FF);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(258, 1'b1);
    start_rx(20'd0, 9'd256);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(5, 1'b1);
    put(KIND_BYTE, CH_EOT);
  endtask

  task automatic test_reply_paths();
    start_rx(20'd0, 9'd8);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(2, 1'b1);
    put(KIND_BYTE, CH_STX);
    send_frame(1, 1'b1);
    put(KIND_ERROR, 8'($urandom));
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    send_frame(1, 1'b1);
    put(KIND_BYTE, 8'h55);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    put(KIND_BYTE, 8'h31);
    start_rx(20'd1600, 9'd4);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_EOT);
    start_rx(20'($urandom), 9'd0);
  endtask

  task automatic test_timeouts();
    set_waits(16'd0, 16'd0);
    start_rx(20'd0, 9'd8);
    put(KIND_BYTE, CH_ENQ);
    put(KIND_TICK, 8'($urandom));
    put(KIND_BYTE, CH_ENQ);
    put(KIND_BYTE, CH_STX);
    put(KIND_BYTE, 8'h10);
    put(KIND_TICK, 8'($urandom));
    put(KIND_BYTE, CH_STX);
    put(KIND_BYTE, CH_ETX);
    put(KIND_TICK, 8'($urandom));
    set_waits(16'd1, 16'hFFFF);
    put(KIND_BYTE, CH_STX);
    send_frame(2, 1'b1);
    put(KIND_TICK, 8'($urandom));
    // enq wait runs out after a good message
    calm = 1'b1;
    repeat (int'(MIN_ENQ_WAIT)) put(KIND_TICK, 8'($urandom));
    calm = 1'b0;
  endtask

  task automatic run_session();
    int         r;
    int         len;
    logic [8:0] bs;
    r = $urandom_range(0, 99);
    if (r < 70) bs = 9'($urandom_range(1, 12));
    else if (r < 92) bs = 9'($urandom_range(13, 300));
    else bs = 9'($urandom_range(0, 511));
    start_rx(20'($urandom), bs);
    line_noise();
    put(KIND_BYTE, CH_ENQ);
    repeat ($urandom_range(1, 3)) begin
      line_noise();
      r = $urandom_range(0, 99);
      if (r < 85) put(KIND_BYTE, CH_STX);
      else if (r < 93) put(KIND_ERROR, 8'($urandom));
      else put(KIND_BYTE, 8'($urandom));
      if (bs <= 12) len = $urandom_range(0, int'(bs) + 1);
      else len = $urandom_range(0, 16);
      send_frame(len, $urandom_range(0, 99) < 80);
    end
    if ($urandom_range(0, 99) < 85) put(KIND_BYTE, CH_EOT);
    else line_noise();
    if ($urandom_range(0, 99) < 4) settle();
  endtask

  task automatic test_random_sessions(int n_items);
    int stop_at;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) run_session();
  endtask

  always @(negedge clk) begin : result_stall
    int r;
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 12);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rx_expected.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item), '0);
      end else begin
        want = rx_expected.pop_front();
        if (out_item.send_valid !== want.send_valid)
          report_mismatch("send_valid", 32'(out_item.send_valid), 32'(want.send_valid));
        if (out_item.send_byte !== want.send_byte)
          report_mismatch("send_byte", 32'(out_item.send_byte), 32'(want.send_byte));
        if (out_item.store_valid !== want.store_valid)
          report_mismatch("store_valid", 32'(out_item.store_valid),
                          32'(want.store_valid));
        if (out_item.store_index !== want.store_index)
          report_mismatch("store_index", 32'(out_item.store_index),
                          32'(want.store_index));
        if (out_item.store_byte !== want.store_byte)
          report_mismatch("store_byte", 32'(out_item.store_byte), 32'(want.store_byte));
        if (out_item.finished !== want.finished)
          report_mismatch("finished", 32'(out_item.finished), 32'(want.finished));
        if (out_item.success !== want.success)
          report_mismatch("success", 32'(out_item.success), 32'(want.success));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm = 1'b0;
    noisy = 1'b0;
    ready_hold = 0;
    errors = 0;
    n_sent = 0;
    m_phase = PH_IDLE;
    m_wait_cnt = '0;
    m_lrc = '0;
    m_wpos = '0;
    m_frame_ok = 1'b0;
    m_msg_ok = 1'b0;
    m_enq_limit = MIN_ENQ_WAIT;
    m_capacity = 9'd1;
    m_reply_wait = REPLY_WAIT_RST;
    m_gap_wait = INTERBYTE_WAIT_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_requests();
    test_clean_message();
    test_rejected_frames();
    test_buffer_limits();
    test_reply_paths();
    test_timeouts();

    noisy = 1'b1;
    set_waits(REPLY_WAIT_RST, INTERBYTE_WAIT_RST);
    test_random_sessions(140);
    set_waits(16'd1, 16'd1);
    test_random_sessions(140);
    calm = 1'b1;
    set_waits(16'hFFFF, 16'hFFFF);
    test_random_sessions(120);
    calm = 1'b0;
    set_waits(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
    test_random_sessions(140);
    set_waits(16'd0, 16'($urandom_range(0, 4)));
    test_random_sessions(120);
    set_waits(16'($urandom), 16'($urandom_range(1, 40)));
    test_random_sessions(140);

    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
sv/estx_rx_pkg.sv
sv/enq_stx_lrc_frame_receiver_core.sv
bench/tb.sv
